// ===== src/hwc_pkg.sv =====
package hwc_pkg;

    localparam int TABLE_BITS_DEF = 15;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [31:0] LETTER_BASE = 32'd97;
    localparam logic [31:0] HASH_INIT   = 32'd0;
    localparam logic [31:0] WEIGHT_INIT = 32'd1;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // write zero at the sweep address, advance it
        logic take_en;  // drive input ready
        logic acc;      // fold the registered product into the hash
        logic upd;      // write back the bucket count, load the output beat
    } t_hwc_cmd;

    // datapath -> controller
    typedef struct packed {
        logic accepted; // input beat taken this cycle
        logic last;     // held character ends its word
        logic clr_done; // sweep is at its final entry
        logic out_free; // output register can take a beat
    } t_hwc_stat;

endpackage

// ===== src/hwc_in_if.sv =====
interface hwc_in_if ();
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] letter;
    logic       word_end;

    modport source (output valid, output req_type, output letter, output word_end,
                    input ready);
    modport sink   (input valid, input req_type, input letter, input word_end,
                    output ready);
endinterface

// ===== src/hwc_out_if.sv =====
interface hwc_out_if #(
    parameter int TABLE_BITS = hwc_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = hwc_pkg::COUNT_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [TABLE_BITS-1:0] bucket;
    logic [COUNT_BITS-1:0] count_after;
    logic                  word_found;
    logic                  all_found;

    modport source (output valid, output bucket, output count_after,
                    output word_found, output all_found, input ready);
    modport sink   (input valid, input bucket, input count_after,
                    input word_found, input all_found, output ready);
endinterface

// ===== src/hwc_ctrl.sv =====
module hwc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hwc_pkg::t_hwc_stat  i_stat,
    output hwc_pkg::t_hwc_cmd   o_cmd
);
    import hwc_pkg::*;

    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_UPD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.take_en = 1'b1;
                if (i_stat.accepted) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last ? ST_UPD : ST_IDLE;
            end
            ST_UPD: begin
                // hold until the output register has room
                if (i_stat.out_free) begin
                    o_cmd.upd = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/hwc_dp.sv =====
module hwc_dp #(
    parameter int TABLE_BITS = hwc_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = hwc_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hwc_pkg::t_hwc_cmd   i_cmd,
    output hwc_pkg::t_hwc_stat  o_stat,
    hwc_in_if.sink              i_in,
    hwc_out_if.source           o_out
);
    import hwc_pkg::*;

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    logic [COUNT_BITS-1:0] mem [TABLE_SIZE];

    logic [31:0]           r_hash;
    logic [31:0]           r_weight;
    logic [31:0]           r_prod;
    logic                  r_demand;
    logic                  r_last;
    logic [TABLE_BITS-1:0] r_idx;
    logic [TABLE_BITS-1:0] r_clr_addr;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_missing;

    logic                  r_out_valid;
    logic [TABLE_BITS-1:0] r_bucket;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_found;
    logic                  r_all;

    logic                  accepted;
    logic [31:0]           n_prod;
    logic [31:0]           n_weight;
    logic [31:0]           n_sum;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_found;
    logic                  n_missing;
    logic                  wr_en;
    logic [TABLE_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    assign i_in.ready = i_cmd.take_en;
    assign accepted   = i_in.valid & i_cmd.take_en;

    assign n_prod   = ({24'd0, i_in.letter} - LETTER_BASE) * r_weight;
    assign n_weight = i_in.word_end ? WEIGHT_INIT : (r_weight + {r_weight[30:0], 1'b0});
    assign n_sum    = r_hash + r_prod;

    // count update from the word's bucket
    always_comb begin
        n_count   = r_rd_data;
        n_found   = 1'b0;
        n_missing = r_missing;
        priority if (!r_demand) begin
            if (r_rd_data != '1) begin
                n_count = r_rd_data + 1'b1;
            end
            n_found = 1'b1;
        end else if (r_missing) begin
            n_found = 1'b0;
        end else if (r_rd_data != '0) begin
            n_count = r_rd_data - 1'b1;
            n_found = 1'b1;
        end else begin
            n_missing = 1'b1;
        end
    end

    assign wr_en   = i_cmd.clr | i_cmd.upd;
    assign wr_addr = i_cmd.clr ? r_clr_addr : r_idx;
    assign wr_data = i_cmd.clr ? '0 : n_count;

    // hold the bucket's count from the hash step until the update is done
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.acc) begin
            r_rd_data <= mem[n_sum[TABLE_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_prod   <= n_prod;
            r_demand <= i_in.req_type;
            r_last   <= i_in.word_end;
        end
        if (i_cmd.acc) begin
            r_idx <= n_sum[TABLE_BITS-1:0];
        end
        if (i_cmd.upd) begin
            r_bucket <= r_idx;
            r_count  <= n_count;
            r_found  <= n_found;
            r_all    <= ~n_missing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= HASH_INIT;
            r_weight    <= WEIGHT_INIT;
            r_clr_addr  <= '0;
            r_missing   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accepted) begin
                r_weight <= n_weight;
            end
            if (i_cmd.acc) begin
                r_hash <= r_last ? HASH_INIT : n_sum;
            end
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.upd) begin
                r_missing   <= n_missing;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.accepted = accepted;
    assign o_stat.last     = r_last;
    assign o_stat.clr_done = (r_clr_addr == '1);
    assign o_stat.out_free = ~r_out_valid | o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.bucket      = r_bucket;
    assign o_out.count_after = r_count;
    assign o_out.word_found  = r_found;
    assign o_out.all_found   = r_all;

endmodule

// ===== src/hashed_word_count_check.sv =====
// Steps: a character is accepted with its multiply, then added into the hash;
//   a word-ending character also reads its bucket in the add step, then writes back
//   the updated count and loads its output beat, waiting while the previous beat is untaken.
// A new character is taken only once the previous one is through these steps.
// Reset: synchronous, active low; afterwards all 2**TABLE_BITS table entries
//   (32768 by default) are swept to zero, and no input beat is taken until it is done.
module hashed_word_count_check #(
    parameter int TABLE_BITS = hwc_pkg::TABLE_BITS_DEF,
    parameter int COUNT_BITS = hwc_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hwc_in_if.sink    i_in,
    hwc_out_if.source o_out
);
    import hwc_pkg::*;

    // Controller sequences the sweep and the per-character steps:
    //   CLR  - write zero into one table entry per cycle
    //   IDLE - take a character beat; multiply (letter - 'a') by the place weight
    //   ACC  - add the product into the running hash; at word end, read the bucket
    //   UPD  - apply increment/decrement, write back, and load the output beat
    // UPD stalls only while a previous output beat is still waiting to be taken.
    t_hwc_cmd  cmd;
    t_hwc_stat stat;

    hwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath holds the hash, place weight, sticky missing flag, the count table
    // and the output register; it owns both channel handshakes.
    hwc_dp #(
        .TABLE_BITS (TABLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== dv/testbench.sv =====
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import hwc_pkg::*;

    // Widths follow the default build of the block.
    localparam int TBITS = TABLE_BITS_DEF;
    localparam int CBITS = COUNT_BITS_DEF;
    localparam int TABLE_DEPTH = 1 << TBITS;
    localparam logic [CBITS-1:0] COUNT_TOP = '1;
    localparam logic [31:0] WEIGHT_STEP = 32'd3;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_Z = 8'h7A;

    localparam int MAX_LEN = 24;
    localparam int MAX_PRINTS = 30;
    // The limit covers the table sweep plus about 1300 characters,
    // idling and hold-offs included.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // Kind of word, decided by the req_type of its last character.
    typedef enum bit {
        SUPPLY = 1'b0,
        DEMAND = 1'b1
    } req_kind_e;

    // One output beat as the block should present it.
    typedef struct packed {
        logic [TBITS-1:0] bucket;
        logic [CBITS-1:0] count;
        logic             found;
        logic             all;
    } tally_t;

    typedef struct {
        int         len;
        logic [7:0] chars [MAX_LEN];
    } word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hwc_in_if in_if ();
    hwc_out_if #(.TABLE_BITS(TBITS), .COUNT_BITS(CBITS)) out_if ();

    hashed_word_count_check #(
        .TABLE_BITS(TBITS),
        .COUNT_BITS(CBITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // 12 ns period, high and low halves.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: running hash, place weight, bucket counts and the
    // sticky miss flag, all at the block's widths.
    // ------------------------------------------------------------------
    logic [31:0]      run_hash   = HASH_INIT;
    logic [31:0]      run_weight = WEIGHT_INIT;
    bit   [CBITS-1:0] bucket_count [TABLE_DEPTH];
    bit               missing_seen;

    // Output beats still owed by the block, oldest first.
    tally_t due_tallies [$];

    // Words supplied but not yet demanded back; demands drawn from here hit until a miss is seen.
    word_t supplied_words [$];

    int          send_idle_pct;
    int          take_stall_pct;
    int          hold_left;
    int          chars_sent;
    int          mismatch_count;
    int unsigned cycle_count;

    // Fold one accepted character into the hash; at word end, apply the
    // table operation and queue the beat it should produce.
    function automatic void tally_char(req_kind_e kind, logic [7:0] ch, logic last);
        tally_t           t;
        logic [TBITS-1:0] idx;
        logic [CBITS-1:0] cnt;
        logic             found;
        run_hash   = run_hash + ({24'd0, ch} - LETTER_BASE) * run_weight;
        run_weight = run_weight * WEIGHT_STEP;
        if (last) begin
            idx = run_hash[TBITS-1:0];
            cnt = bucket_count[idx];
            if (kind == SUPPLY) begin
                // Saturate: a full count stays put but still reports found.
                if (cnt != COUNT_TOP)
                    cnt = cnt + 1'b1;
                found = 1'b1;
            end else if (missing_seen) begin
                // After a miss, demands leave the table alone.
                found = 1'b0;
            end else if (cnt != '0) begin
                cnt   = cnt - 1'b1;
                found = 1'b1;
            end else begin
                missing_seen = 1'b1;
                found        = 1'b0;
            end
            bucket_count[idx] = cnt;
            run_hash   = HASH_INIT;
            run_weight = WEIGHT_INIT;
            t.bucket = idx;
            t.count  = cnt;
            t.found  = found;
            t.all    = !missing_seen;
            due_tallies.push_back(t);
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input side. Entered and left at a falling edge; valid stays high
    // across back-to-back beats so it is never dropped and raised in the
    // same step.
    // ------------------------------------------------------------------
    task automatic send_char(req_kind_e kind, logic [7:0] ch, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.req_type <= kind;
        in_if.letter   <= ch;
        in_if.word_end <= last;
        // Hold the beat until the block takes it.
        do
            @(posedge i_clk);
        while (!in_if.ready);
        tally_char(kind, ch, last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    // Characters before the last carry a random req_type: only the last one
    // decides what the word does.
    task automatic send_word(req_kind_e kind, word_t w);
        req_kind_e kind_now;
        for (int i = 0; i < w.len; i++) begin
            kind_now = (i == w.len - 1) ? kind : req_kind_e'($urandom_range(1));
            send_char(kind_now, w.chars[i], i == w.len - 1);
        end
    endtask

    function automatic word_t random_word(bit any_bytes);
        word_t w;
        // Mostly short words; now and then long enough for the weight to wrap.
        w.len = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN, 7) : $urandom_range(6, 1);
        for (int i = 0; i < MAX_LEN; i++) begin
            if (any_bytes || $urandom_range(4) == 0)
                w.chars[i] = $urandom_range(255);
            else
                w.chars[i] = $urandom_range(CH_Z, CH_A);
        end
        return w;
    endfunction

    task automatic supply_fresh(bit any_bytes);
        word_t w;
        w = random_word(any_bytes);
        send_word(SUPPLY, w);
        supplied_words.push_back(w);
    endtask

    task automatic demand_pooled();
        word_t w;
        int    pick;
        if (supplied_words.size() == 0) begin
            supply_fresh(1'b0);
        end else begin
            pick = $urandom_range(supplied_words.size() - 1);
            w    = supplied_words[pick];
            supplied_words.delete(pick);
            send_word(DEMAND, w);
        end
    endtask

    // Change idling between edges opposite to where it is read.
    task automatic set_idling(int send_pct, int take_pct);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        take_stall_pct = take_pct;
        @(negedge i_clk);
    endtask

    // Park the input and wait until every owed beat has come back.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (due_tallies.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready changes at the falling edge. A hold-off, when
    // requested, keeps ready low for that many cycles in a row.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Compare every accepted output beat with the oldest owed one.
    always @(posedge i_clk) begin
        tally_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (due_tallies.size() == 0) begin
                report_mismatch("beat with nothing owed, bucket", out_if.bucket, 0);
            end else begin
                want = due_tallies.pop_front();
                if (out_if.bucket !== want.bucket)
                    report_mismatch("bucket", out_if.bucket, want.bucket);
                if (out_if.count_after !== want.count)
                    report_mismatch("count_after", out_if.count_after, want.count);
                if (out_if.word_found !== want.found)
                    report_mismatch("word_found", out_if.word_found, want.found);
                if (out_if.all_found !== want.all)
                    report_mismatch("all_found", out_if.all_found, want.all);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Letter extremes, mixed req_type inside a word, and demands that hit.
    task automatic test_letter_extremes();
        set_idling(0, 0);
        // Single letters: 'a' lands in bucket zero, 0x00 wraps below 'a', 0xFF sits above 'z'.
        send_char(SUPPLY, CH_A, 1'b1);
        send_char(SUPPLY, 8'h00, 1'b1);
        send_char(SUPPLY, 8'hFF, 1'b1);
        send_char(SUPPLY, CH_Z, 1'b1);
        // "abc" with demand characters inside a supply word.
        send_char(DEMAND, CH_A, 1'b0);
        send_char(DEMAND, CH_B, 1'b0);
        send_char(SUPPLY, CH_C, 1'b1);
        // The same word back as a demand with supply characters inside.
        send_char(SUPPLY, CH_A, 1'b0);
        send_char(SUPPLY, CH_B, 1'b0);
        send_char(DEMAND, CH_C, 1'b1);
        // A long word of 'z' pushes the place weight up.
        for (int i = 0; i < 12; i++)
            send_char(SUPPLY, CH_Z, i == 11);
        // Take back the 0x00 and 0xFF words.
        send_char(DEMAND, 8'h00, 1'b1);
        send_char(DEMAND, 8'hFF, 1'b1);
    endtask

    // Hammer one bucket back to back so each update after the first hits the
    // entry just written, then step it down again.
    task automatic test_bucket_hammer();
        set_idling(0, 0);
        repeat (40)
            send_char(SUPPLY, CH_A, 1'b1);
        send_char(SUPPLY, CH_A, 1'b1);
        send_char(DEMAND, CH_A, 1'b1);
        send_char(DEMAND, CH_A, 1'b1);
    endtask

    // Mostly supply-then-demand traffic that keeps hitting, with some
    // all-random byte words as noise. Demands of unknown words only once a
    // miss is allowed, since it sticks.
    task automatic test_mixed_traffic(int send_pct, int take_pct, int n_chars, bit allow_miss);
        int start;
        int roll;
        set_idling(send_pct, take_pct);
        start = chars_sent;
        while (chars_sent - start < n_chars) begin
            roll = $urandom_range(99);
            if (roll < 45)
                supply_fresh(1'b0);
            else if (roll < 80)
                demand_pooled();
            else if (roll < 90 || !allow_miss)
                supply_fresh(1'b1);
            else
                send_word(DEMAND, random_word($urandom_range(1)));
        end
    endtask

    // Hold the output off for a long stretch while words keep coming so the
    // block backs up into its input, then pause until everything is back.
    task automatic test_output_hold_off();
        int start;
        set_idling(0, 0);
        @(posedge i_clk);
        hold_left = 400;
        @(negedge i_clk);
        start = chars_sent;
        while (chars_sent - start < 60) begin
            if ($urandom_range(1))
                supply_fresh(1'b0);
            else
                demand_pooled();
        end
        drain_results();
    endtask

    // Demand a word whose bucket is empty, then check the sticky flag: later
    // demands leave the table alone, supplies still count.
    task automatic test_missing_word();
        logic [31:0] h;
        int          pick;
        set_idling(0, 0);
        pick = 0;
        for (int v = 255; v >= 0; v--) begin
            h = 32'(v) - LETTER_BASE;
            if (bucket_count[h[TBITS-1:0]] == '0)
                pick = v;
        end
        send_char(DEMAND, pick[7:0], 1'b1);
        demand_pooled();
        supply_fresh(1'b0);
        demand_pooled();
        test_mixed_traffic(22, 22, 150, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Drive every input to a known value from the start.
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.req_type  = SUPPLY;
        in_if.letter    = '0;
        in_if.word_end  = 1'b0;
        out_if.ready    = 1'b0;
        send_idle_pct   = 0;
        take_stall_pct  = 0;
        hold_left       = 0;
        chars_sent      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        missing_seen    = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The first beat waits out the table sweep on its own.
        test_letter_extremes();
        test_bucket_hammer();
        test_mixed_traffic(0, 0, 250, 1'b0);
        test_mixed_traffic(73, 0, 250, 1'b0);
        test_mixed_traffic(0, 73, 250, 1'b0);
        test_mixed_traffic(22, 22, 250, 1'b0);
        test_output_hold_off();
        test_missing_word();

        // Drop valid, collect what is still owed, then let the pipeline settle.
        in_if.valid <= 1'b0;
        while (due_tallies.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && due_tallies.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
